### src/hxdec_pkg.sv
// Shared types, character codes and the hex digit decoder for the hex-to-decimal text block.
`default_nettype none

package hxdec_pkg;

  // Input beat: one character of the string
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_beat_t;

  // Output beat: one character of decimal text, or an error marker
  typedef struct packed {
    logic [7:0] out_char;
    logic       error;
    logic       last_out;
  } out_beat_t;

  // Decoded hex digit
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_digit_t;

  localparam logic [7:0] CHAR_LOWER_X = 8'h78;  // 'x'
  localparam logic [7:0] CHAR_UPPER_X = 8'h58;  // 'X'
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;  // 'f'
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;  // 'F'
  localparam logic [7:0] CHAR_NUL     = 8'h00;

  // Map an ASCII code to its hex digit value; ok is low for anything else
  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    logic [7:0] t;
    d = '{ok: 1'b0, val: 4'd0};
    t = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = c - CHAR_ZERO;
      d = '{ok: 1'b1, val: t[3:0]};
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      t = c - CHAR_LOWER_A + 8'd10;
      d = '{ok: 1'b1, val: t[3:0]};
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      t = c - CHAR_UPPER_A + 8'd10;
      d = '{ok: 1'b1, val: t[3:0]};
    end
    return d;
  endfunction

endpackage

`default_nettype wire

### src/hex_text_to_decimal_text.sv
// Top level: hex string parser and iterative binary-to-decimal text converter.
//
//  channel | ports                         | payload     | direction
//  --------+-------------------------------+-------------+----------
//  input   | in_valid / in_ready / in_data | in_beat_t   | in
//  output  | out_valid / out_ready/out_data| out_beat_t  | out
//
// A non-final character is taken while idle; a malformed string yields one error beat.
// A well-formed final character starts the conversion: shift-and-add-3 of each magnitude
// bit via one shared BCD unit, leading-zero drop, then one beat per cycle unless stalled.
// in_ready is low from the final character until its last output beat is loaded.
// Output is held in a register, so a stalled consumer only stalls emission.
// Reset (rst_n low, synchronous) clears the parser state and drops out_valid.
`default_nettype none

module hex_text_to_decimal_text
  import hxdec_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  wire       out_ready,
  output out_beat_t out_data
);

  // Enough decimal digits for 2**VALUE_BITS (77/256 slightly below log10(2))
  localparam int DIGITS = (VALUE_BITS * 77) / 256 + 1;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int CNT_W  = $clog2(DIGITS + 1);
  localparam int BIT_W  = $clog2(VALUE_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ERR,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_t;

  state_t                  state_r, state_nxt;
  logic [1:0]              pos_r, pos_nxt;
  logic [VALUE_BITS-1:0]   acc_r, acc_nxt;
  logic                    bad_r, bad_nxt;
  logic                    neg_r, neg_nxt;
  logic [VALUE_BITS-1:0]   mag_r, mag_nxt;
  logic [BCD_W-1:0]        bcd_r, bcd_nxt;
  logic [BIT_W-1:0]        bit_cnt_r, bit_cnt_nxt;
  logic [CNT_W-1:0]        dig_cnt_r, dig_cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_beat_t               out_data_r, out_data_nxt;

  logic [3:0] top_digit;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign top_digit = bcd_r[BCD_W-1 -: 4];
  assign out_free  = !out_valid_r || out_ready;

  // Sequencer and shared shift/add-3 unit
  always_comb begin
    logic [BCD_W-1:0]      adj;
    hex_digit_t            hd;
    logic                  bad_c;
    logic [VALUE_BITS-1:0] acc_c;

    state_nxt     = state_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    bad_nxt       = bad_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    hd    = hex_decode(in_data.char_code);
    bad_c = bad_r;
    acc_c = acc_r;

    // add 3 to every BCD digit of 5 or more, digits are independent
    adj = bcd_r;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // format check and hex accumulate for this character
          if (pos_r == 2'd1) begin
            if (in_data.char_code != CHAR_LOWER_X && in_data.char_code != CHAR_UPPER_X) begin
              bad_c = 1'b1;
            end
          end else if (pos_r == 2'd2) begin
            if (!hd.ok) begin
              bad_c = 1'b1;
            end else begin
              acc_c = {acc_r[VALUE_BITS-5:0], hd.val};
            end
          end

          if (!in_data.last_char) begin
            pos_nxt = (pos_r == 2'd2) ? 2'd2 : pos_r + 2'd1;
            acc_nxt = acc_c;
            bad_nxt = bad_c;
          end else begin
            pos_nxt = 2'd0;
            acc_nxt = '0;
            bad_nxt = 1'b0;
            if (bad_c || pos_r == 2'd0) begin
              state_nxt = ST_ERR;
            end else begin
              // two's complement magnitude; the most negative value maps to itself
              neg_nxt     = acc_c[VALUE_BITS-1];
              mag_nxt     = acc_c[VALUE_BITS-1] ? (~acc_c + 1'b1) : acc_c;
              bcd_nxt     = '0;
              bit_cnt_nxt = BIT_W'(VALUE_BITS);
              state_nxt   = ST_CONV;
            end
          end
        end
      end

      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_char: CHAR_NUL, error: 1'b1, last_out: 1'b1};
          state_nxt     = ST_IDLE;
        end
      end

      // one magnitude bit per cycle into the BCD register
      ST_CONV: begin
        bcd_nxt     = {adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
        mag_nxt     = {mag_r[VALUE_BITS-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == BIT_W'(1)) begin
          dig_cnt_nxt = CNT_W'(DIGITS);
          state_nxt   = ST_SKIP;
        end
      end

      // drop leading zeros, keep at least one digit
      ST_SKIP: begin
        if (top_digit == 4'd0 && dig_cnt_r > CNT_W'(1)) begin
          bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
          dig_cnt_nxt = dig_cnt_r - 1'b1;
        end else begin
          state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
        end
      end

      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_char: CHAR_MINUS, error: 1'b0, last_out: 1'b0};
          state_nxt     = ST_DIGIT;
        end
      end

      ST_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{out_char: CHAR_ZERO | {4'd0, top_digit}, error: 1'b0,
                            last_out: (dig_cnt_r == CNT_W'(1))};
          bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
          dig_cnt_nxt   = dig_cnt_r - 1'b1;
          if (dig_cnt_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= 2'd0;
      acc_r       <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
      bit_cnt_r   <= '0;
      dig_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      acc_r       <= acc_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
    end
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    out_data_r <= out_data_nxt;
  end

  // Error beats are single, final and carry a zero character
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error |-> out_data.last_out && out_data.out_char == CHAR_NUL)
    else $error("error beat malformed");

  // The sign is never the final beat
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_char == CHAR_MINUS |-> !out_data.last_out && !out_data.error)
    else $error("sign beat marked last");

  // Non-error, non-sign beats are decimal digits
  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.error && out_data.out_char != CHAR_MINUS
      |-> out_data.out_char >= CHAR_ZERO && out_data.out_char <= CHAR_NINE)
    else $error("digit beat out of range");

  // Conversion never runs with an exhausted bit count
  a_conv_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CONV |-> bit_cnt_r != '0)
    else $error("conversion bit counter underflow");

  // A digit is only emitted while digits remain
  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIGIT |-> dig_cnt_r != '0)
    else $error("digit counter underflow");

endmodule

`default_nettype wire
